// ===== rtl/i2c_master_register_access_sequencer_unit_assert.svh =====
// Assertion helpers for the register access sequencer.
// Both sample on the rising edge of clk; the first one is muted during reset.
`ifndef I2C_MASTER_REGISTER_ACCESS_SEQUENCER_UNIT_ASSERT_SVH
`define I2C_MASTER_REGISTER_ACCESS_SEQUENCER_UNIT_ASSERT_SVH

// Property checked only while out of reset
`define I2CRS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sequencer assertion failed");

// Property checked at every edge, reset included
`define I2CRS_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("sequencer assertion failed");

`endif

// ===== rtl/i2crs_pkg.sv =====
`default_nettype none
package i2crs_pkg;

	// Largest transfer length and the transmit buffer slots reachable by a load
	localparam int MAX_BYTES_DEF = 16;
	localparam int LOAD_SLOTS = 16;

	// Entries in the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	// Bus controller status codes, low three bits dropped
	localparam logic [7:0] STATUS_MASK       = 8'hF8;
	localparam logic [7:0] TWI_START         = 8'h08;
	localparam logic [7:0] TWI_RSTART        = 8'h10;
	localparam logic [7:0] TWI_SLAW_ACK      = 8'h18;
	localparam logic [7:0] TWI_TX_DATA_ACK   = 8'h28;
	localparam logic [7:0] TWI_SLAR_ACK      = 8'h40;
	localparam logic [7:0] TWI_RX_DATA_ACK   = 8'h50;
	localparam logic [7:0] TWI_RX_DATA_NACK  = 8'h58;

	typedef enum logic [1:0] {
		CMD_START_READ  = 2'd0,
		CMD_START_WRITE = 2'd1,
		CMD_BUS_EVENT   = 2'd2,
		CMD_LOAD_BYTE   = 2'd3
	} cmd_t;

	// Status as classified by the front
	typedef enum logic [2:0] {
		ST_START,
		ST_RSTART,
		ST_SLAW_ACK,
		ST_TX_DATA_ACK,
		ST_SLAR_ACK,
		ST_RX_DATA_ACK,
		ST_RX_DATA_NACK,
		ST_OTHER
	} status_t;

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RD_START  = 4'd1,
		PH_RD_SLAW   = 4'd2,
		PH_RD_REG    = 4'd3,
		PH_RD_RSTART = 4'd4,
		PH_RD_SLAR   = 4'd5,
		PH_RD_DATA   = 4'd6,
		PH_WR_START  = 4'd7,
		PH_WR_SLAW   = 4'd8,
		PH_WR_REG    = 4'd9,
		PH_WR_DATA   = 4'd10,
		PH_ERROR     = 4'd11
	} phase_t;

	// Classified request held in the queue
	typedef struct packed {
		cmd_t        cmd;
		logic [6:0]  slave_addr;
		logic [7:0]  reg_addr;
		logic [4:0]  count;
		status_t     status;
		logic [7:0]  rx_byte;
		logic [3:0]  load_index;
		logic [7:0]  load_data;
	} req_t;

	// Queue fill status seen by the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	// One result item
	typedef struct packed {
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        send_start;
		logic        send_stop;
		logic        ack_enable;
		logic        release_bus;
		logic        rx_valid;
		logic [3:0]  rx_index;
		logic [7:0]  rx_data;
		logic        error_flag;
		logic        ready_res;
	} result_t;

endpackage
`default_nettype wire

// ===== rtl/i2crs_front.sv =====
`default_nettype none
module i2crs_front #(
	parameter int MAX_BYTES = 16
) (
	input  wire logic [1:0] command,
	input  wire logic [6:0] slave_addr,
	input  wire logic [7:0] reg_addr,
	input  wire logic [4:0] byte_count,
	input  wire logic [7:0] twi_status,
	input  wire logic [7:0] rx_byte,
	input  wire logic [3:0] load_index,
	input  wire logic [7:0] load_data,
	output i2crs_pkg::req_t req
);
	import i2crs_pkg::*;

	// Longest count the 5-bit field can carry after saturation
	localparam logic [4:0] SatCount = (MAX_BYTES > 31) ? 5'd31 : 5'(MAX_BYTES);

	logic [7:0] status_m;
	logic [4:0] cnt;
	status_t    st;

	// Count: zero behaves as one, then clip to the largest transfer
	always_comb begin
		cnt = (byte_count == 5'd0) ? 5'd1 : byte_count;
		if (cnt > SatCount) begin
			cnt = SatCount;
		end
	end

	// Status classification
	assign status_m = twi_status & STATUS_MASK;

	always_comb begin
		case (status_m)
			TWI_START:        st = ST_START;
			TWI_RSTART:       st = ST_RSTART;
			TWI_SLAW_ACK:     st = ST_SLAW_ACK;
			TWI_TX_DATA_ACK:  st = ST_TX_DATA_ACK;
			TWI_SLAR_ACK:     st = ST_SLAR_ACK;
			TWI_RX_DATA_ACK:  st = ST_RX_DATA_ACK;
			TWI_RX_DATA_NACK: st = ST_RX_DATA_NACK;
			default:          st = ST_OTHER;
		endcase
	end

	always_comb begin
		req.cmd        = cmd_t'(command);
		req.slave_addr = slave_addr;
		req.reg_addr   = reg_addr;
		req.count      = cnt;
		req.status     = st;
		req.rx_byte    = rx_byte;
		req.load_index = load_index;
		req.load_data  = load_data;
	end

endmodule
`default_nettype wire

// ===== rtl/i2crs_queue.sv =====
`default_nettype none
module i2crs_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire i2crs_pkg::req_t  push_req,
	input  wire logic             pop,
	output i2crs_pkg::req_t       pop_req,
	output i2crs_pkg::q_status_t  status
);
	import i2crs_pkg::*;

	localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CntW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);

	req_t            mem_q [QUEUE_DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	assign pop_req      = mem_q[rd_ptr_q];
	assign status.full  = (count_q == CntW'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);

endmodule
`default_nettype wire

// ===== rtl/i2crs_back.sv =====
`default_nettype none
module i2crs_back #(
	parameter int MAX_BYTES = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire i2crs_pkg::q_status_t q_status,
	input  wire i2crs_pkg::req_t      req,
	output logic                      pop,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output i2crs_pkg::result_t        result
);
	import i2crs_pkg::*;

	// Only slots a load can reach are kept
	localparam int BufDepth = (MAX_BYTES < LOAD_SLOTS) ? MAX_BYTES : LOAD_SLOTS;
	localparam int BufIdxW  = (BufDepth > 1) ? $clog2(BufDepth) : 1;
	localparam logic [4:0] BufLimit = 5'(BufDepth);

	phase_t      phase_q, phase_d;
	logic [6:0]  addr_q, addr_d;
	logic [7:0]  reg_q, reg_d;
	logic [4:0]  total_q, total_d;
	logic [4:0]  pos_q, pos_d;
	logic        ack_q, ack_d;

	logic [7:0]  buf_q [BufDepth];
	logic [4:0]  buf_idx;
	logic [7:0]  buf_rd;

	logic        is_start, is_event, is_load;
	logic        checked, ev_ok;
	logic [4:0]  pos_inc;
	logic [5:0]  pos_look;

	result_t     res_d;
	result_t     result_q;
	logic        out_valid_q;

	// Pop whenever the output register is free or being drained
	assign pop = !q_status.empty && (!out_valid_q || !out_stall);

	assign is_start = (req.cmd == CMD_START_READ) || (req.cmd == CMD_START_WRITE);
	assign is_event = (req.cmd == CMD_BUS_EVENT);
	assign is_load  = (req.cmd == CMD_LOAD_BYTE);

	assign pos_inc  = pos_q + 5'd1;
	assign pos_look = {1'b0, pos_inc} + 6'd1;

	// Expected status for the current phase
	always_comb begin
		checked = 1'b1;
		ev_ok   = 1'b0;
		case (phase_q)
			PH_RD_START, PH_WR_START: ev_ok = (req.status == ST_START);
			PH_RD_SLAW, PH_WR_SLAW:   ev_ok = (req.status == ST_SLAW_ACK);
			PH_RD_REG, PH_WR_REG,
			PH_WR_DATA:               ev_ok = (req.status == ST_TX_DATA_ACK);
			PH_RD_RSTART:             ev_ok = (req.status == ST_RSTART);
			PH_RD_SLAR:               ev_ok = (req.status == ST_SLAR_ACK);
			PH_RD_DATA:               ev_ok = (req.status == ST_RX_DATA_ACK) ||
			                                  (req.status == ST_RX_DATA_NACK);
			default:                  checked = 1'b0;
		endcase
	end

	// Transmit buffer read: slot 0 for the first data byte, else the position
	assign buf_idx = (phase_q == PH_WR_REG) ? 5'd0 : pos_q;
	assign buf_rd  = (buf_idx < BufLimit) ? buf_q[buf_idx[BufIdxW-1:0]] : 8'd0;

	// Next state
	always_comb begin
		phase_d = phase_q;
		addr_d  = addr_q;
		reg_d   = reg_q;
		total_d = total_q;
		pos_d   = pos_q;
		ack_d   = ack_q;
		if (is_start) begin
			if (phase_q == PH_IDLE) begin
				addr_d  = req.slave_addr;
				reg_d   = req.reg_addr;
				total_d = req.count;
				pos_d   = 5'd0;
				ack_d   = 1'b1;
				phase_d = (req.cmd == CMD_START_READ) ? PH_RD_START : PH_WR_START;
			end
		end else if (is_event) begin
			if (checked && !ev_ok) begin
				phase_d = PH_ERROR;
			end else begin
				case (phase_q)
					PH_IDLE:      phase_d = PH_IDLE;
					PH_RD_START:  phase_d = PH_RD_SLAW;
					PH_WR_START:  phase_d = PH_WR_SLAW;
					PH_RD_SLAW:   phase_d = PH_RD_REG;
					PH_WR_SLAW:   phase_d = PH_WR_REG;
					PH_RD_REG:    phase_d = PH_RD_RSTART;
					PH_RD_RSTART: phase_d = PH_RD_SLAR;
					PH_RD_SLAR: begin
						pos_d   = 5'd0;
						ack_d   = (total_q > 5'd1);
						phase_d = PH_RD_DATA;
					end
					PH_RD_DATA: begin
						pos_d = pos_inc;
						if (req.status == ST_RX_DATA_NACK) begin
							ack_d   = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							ack_d = (pos_look < {1'b0, total_q});
						end
					end
					PH_WR_REG: begin
						ack_d   = 1'b1;
						pos_d   = 5'd1;
						phase_d = PH_WR_DATA;
					end
					PH_WR_DATA: begin
						ack_d = 1'b1;
						if (pos_q < total_q) begin
							pos_d = pos_inc;
						end else begin
							phase_d = PH_IDLE;
						end
					end
					PH_ERROR:     phase_d = PH_IDLE;
					default:      phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// Result fields
	always_comb begin
		res_d = '0;
		if (is_start) begin
			if (phase_q == PH_IDLE) begin
				res_d.send_start  = 1'b1;
				res_d.release_bus = 1'b1;
			end
		end else if (is_event) begin
			res_d.release_bus = checked || (phase_q == PH_ERROR);
			if (checked && !ev_ok) begin
				res_d.error_flag = 1'b1;
			end else begin
				case (phase_q)
					PH_RD_START, PH_WR_START: begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = {addr_q, 1'b0};
					end
					PH_RD_SLAW, PH_WR_SLAW: begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = reg_q;
					end
					PH_RD_REG:    res_d.send_start = 1'b1;
					PH_RD_RSTART: begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = {addr_q, 1'b1};
					end
					PH_RD_DATA: begin
						res_d.rx_valid  = 1'b1;
						res_d.rx_index  = pos_q[3:0];
						res_d.rx_data   = req.rx_byte;
						res_d.send_stop = (req.status == ST_RX_DATA_NACK);
					end
					PH_WR_REG: begin
						res_d.tx_valid = 1'b1;
						res_d.tx_byte  = buf_rd;
					end
					PH_WR_DATA: begin
						if (pos_q < total_q) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = buf_rd;
						end else begin
							res_d.send_stop = 1'b1;
						end
					end
					PH_ERROR:     res_d.send_stop = 1'b1;
					default:      res_d.tx_valid = 1'b0;
				endcase
			end
		end
		res_d.ack_enable = ack_d;
		res_d.ready_res  = (phase_d == PH_IDLE);
	end

	// Sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			reg_q   <= '0;
			total_q <= '0;
			pos_q   <= '0;
			ack_q   <= 1'b1;
		end else if (pop) begin
			phase_q <= phase_d;
			addr_q  <= addr_d;
			reg_q   <= reg_d;
			total_q <= total_d;
			pos_q   <= pos_d;
			ack_q   <= ack_d;
		end
	end

	// Transmit buffer, loads beyond the kept slots are dropped
	always_ff @(posedge clk) begin
		if (pop && is_load && ({1'b0, req.load_index} < BufLimit)) begin
			buf_q[req.load_index[BufIdxW-1:0]] <= req.load_data;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule
`default_nettype wire

// ===== rtl/i2c_master_register_access_sequencer_unit.sv =====
// Channel   Handshake              Carries
// in        in_valid / in_stall    command, addresses, count, status, rx and load bytes
// out       out_valid / out_stall  bus actions, received byte, error, ready
//
// One request per cycle sustained while out_stall is low; each request gives exactly one result.
// Requests are classified into a two-entry queue, then sequenced into the
// output register. The back stage state update is the sequencing loop.
// arst_n clears queue pointers, sequencer state and output valid; the transmit
// buffer holds nothing defined until loaded. in_stall rises only when the
// queue is full; out_stall holds the output register and backs up the queue.
`default_nettype none
`include "i2c_master_register_access_sequencer_unit_assert.svh"
module i2c_master_register_access_sequencer_unit #(
	parameter int MAX_BYTES = i2crs_pkg::MAX_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	input  wire logic [6:0] slave_addr,
	input  wire logic [7:0] reg_addr,
	input  wire logic [4:0] byte_count,
	input  wire logic [7:0] twi_status,
	input  wire logic [7:0] rx_byte,
	input  wire logic [3:0] load_index,
	input  wire logic [7:0] load_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            tx_valid,
	output logic [7:0]      tx_byte,
	output logic            send_start,
	output logic            send_stop,
	output logic            ack_enable,
	output logic            release_bus,
	output logic            rx_valid,
	output logic [3:0]      rx_index,
	output logic [7:0]      rx_data,
	output logic            error_flag,
	output logic            ready_res
);
	import i2crs_pkg::*;

	req_t      front_req;
	req_t      back_req;
	q_status_t q_status;
	logic      push;
	logic      pop;
	result_t   result;

	// Front: classify the request
	i2crs_front #(
		.MAX_BYTES(MAX_BYTES)
	) u_front (
		.command    (command),
		.slave_addr (slave_addr),
		.reg_addr   (reg_addr),
		.byte_count (byte_count),
		.twi_status (twi_status),
		.rx_byte    (rx_byte),
		.load_index (load_index),
		.load_data  (load_data),
		.req        (front_req)
	);

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	// Queue between front and back
	i2crs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (front_req),
		.pop      (pop),
		.pop_req  (back_req),
		.status   (q_status)
	);

	// Back: sequencer and output register
	i2crs_back #(
		.MAX_BYTES(MAX_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_status  (q_status),
		.req       (back_req),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.result    (result)
	);

	assign tx_valid    = result.tx_valid;
	assign tx_byte     = result.tx_byte;
	assign send_start  = result.send_start;
	assign send_stop   = result.send_stop;
	assign ack_enable  = result.ack_enable;
	assign release_bus = result.release_bus;
	assign rx_valid    = result.rx_valid;
	assign rx_index    = result.rx_index;
	assign rx_data     = result.rx_data;
	assign error_flag  = result.error_flag;
	assign ready_res   = result.ready_res;

	// An accepted request is held in the queue on the next cycle
	`I2CRS_ASSERT(a_push_lands, (in_valid && !in_stall) |=> !q_status.empty)
	// An error aborts the transfer without returning to idle
	`I2CRS_ASSERT(a_err_busy, (out_valid && error_flag) |-> (release_bus && !ready_res))
	// STOP always leaves the sequencer idle
	`I2CRS_ASSERT(a_stop_idle, (out_valid && send_stop) |-> ready_res)
	// A delivered byte never coincides with a transmit or an error
	`I2CRS_ASSERT_ALWAYS(a_rx_excl,
		(arst_n && out_valid && rx_valid) |-> (release_bus && !tx_valid && !error_flag))

endmodule
`default_nettype wire
